>>> sv/fanlh_pkg.sv
package fanlh_pkg;

    localparam int TEMP_W          = 8;
    localparam int SIDX_W          = 2;
    localparam int FIDX_W          = 1;
    localparam int RPM_W           = 13;
    localparam int LVL_W           = 4;
    localparam int PTR_W           = LVL_W + 1;
    localparam int ROM_ROWS        = 16;
    localparam int NUM_LEVELS      = 13;
    localparam int NUM_SENSORS_DEF = 3;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [SIDX_W-1:0]        ACTIVE_SENSOR    = SIDX_W'(1);
    localparam logic signed [TEMP_W-1:0] UNUSED_THRESHOLD = -8'sd1;

    localparam logic signed [TEMP_W-1:0] TRIG_ROM [ROM_ROWS] = '{
        8'sd25, 8'sd38, 8'sd41, 8'sd44, 8'sd47, 8'sd52, 8'sd47, 8'sd52,
        8'sd60, 8'sd63, 8'sd66, 8'sd69, 8'sd75, 8'sd75, 8'sd75, 8'sd75
    };

    localparam logic signed [TEMP_W-1:0] REL_ROM [ROM_ROWS] = '{
        8'sd0,  8'sd34, 8'sd37, 8'sd40, 8'sd43, 8'sd48, 8'sd43, 8'sd48,
        8'sd56, 8'sd59, 8'sd62, 8'sd65, 8'sd72, 8'sd72, 8'sd72, 8'sd72
    };

    localparam logic [RPM_W-1:0] RPM_ROM [ROM_ROWS] = '{
        13'd0,    13'd2450, 13'd2600, 13'd2800,
        13'd3100, 13'd3300, 13'd3100, 13'd3300,
        13'd3700, 13'd4000, 13'd4300, 13'd4600,
        13'd5500, 13'd5500, 13'd5500, 13'd5500
    };

    typedef struct packed {
        logic                    start;
        logic                    up;
        logic                    down;
        logic                    active;
        logic [LVL_W-1:0]        level;
        logic signed [TEMP_W-1:0] temperature;
    } walk_ctrl_t;

    typedef struct packed {
        logic             done;
        logic [LVL_W-1:0] level;
    } walk_stat_t;

    function automatic logic signed [TEMP_W-1:0] trig_at(input logic [LVL_W-1:0] lvl,
                                                         input logic active);
        logic signed [TEMP_W-1:0] thr;
        thr = active ? TRIG_ROM[lvl] : UNUSED_THRESHOLD;
        return thr;
    endfunction

    function automatic logic signed [TEMP_W-1:0] rel_at(input logic [LVL_W-1:0] lvl,
                                                        input logic active);
        logic signed [TEMP_W-1:0] thr;
        thr = active ? REL_ROM[lvl] : UNUSED_THRESHOLD;
        return thr;
    endfunction

    function automatic logic [RPM_W-1:0] rpm_at(input logic [LVL_W-1:0] lvl);
        return RPM_ROM[lvl];
    endfunction

endpackage

>>> sv/fanlh_ram.sv
module fanlh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/fanlh_walk.sv
module fanlh_walk import fanlh_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  walk_ctrl_t ctrl,
    output walk_stat_t stat
);

    logic                     run_reg, run_next;
    logic                     up_reg, up_next;
    logic                     active_reg, active_next;
    logic [LVL_W-1:0]         lvl_reg, lvl_next;
    logic [PTR_W-1:0]         ptr_reg, ptr_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic                     up_ok;
    logic                     down_ok;

    assign up_ok   = (ptr_reg < PTR_W'(NUM_LEVELS)) &&
                     (temp_reg >= trig_at(ptr_reg[LVL_W-1:0], active_reg));
    assign down_ok = (ptr_reg != '0) &&
                     (temp_reg <= rel_at(ptr_reg[LVL_W-1:0], active_reg));

    always_comb begin
        run_next    = run_reg;
        up_next     = up_reg;
        active_next = active_reg;
        lvl_next    = lvl_reg;
        ptr_next    = ptr_reg;
        temp_next   = temp_reg;
        if (ctrl.start) begin
            run_next    = ctrl.up | ctrl.down;
            up_next     = ctrl.up;
            active_next = ctrl.active;
            lvl_next    = ctrl.level;
            ptr_next    = {1'b0, ctrl.level};
            temp_next   = ctrl.temperature;
        end else if (run_reg) begin
            if (up_reg) begin
                if (up_ok) begin
                    lvl_next = ptr_reg[LVL_W-1:0];
                    ptr_next = ptr_reg + PTR_W'(1);
                end else begin
                    run_next = 1'b0;
                end
            end else begin
                if (down_ok) begin
                    lvl_next = LVL_W'(ptr_reg - PTR_W'(1));
                    ptr_next = ptr_reg - PTR_W'(1);
                end else begin
                    run_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
        end
        up_reg     <= up_next;
        active_reg <= active_next;
        lvl_reg    <= lvl_next;
        ptr_reg    <= ptr_next;
        temp_reg   <= temp_next;
    end

    assign stat.done  = !run_reg && !ctrl.start;
    assign stat.level = lvl_reg;

endmodule

>>> sv/fan_level_hysteresis_table.sv
// Channel | Dir | tdata bits (low to high)                         | tuser
// s_      | in  | temperature[7:0] sensor_index[9:8] fan_index[10] | none
// m_      | out | rpm_target[12:0] fan_level[16:13]                | none
//
// A word passes from its accept through S_READ, S_WALK and S_OUT to m_tvalid; in S_WALK the walk
// unit visits k levels (0 to NUM_LEVELS), none when the sample equals the last one or its sensor
// is absent. s_tready rises with m_tvalid, so no new word is taken while one is in flight. The
// per-sensor last temperature sits in a RAM with a registered read.
// Reset clears the level, the sensor valid bits and m_tvalid, and sets s_tready via S_IDLE.
// A waiting result on m_ does not block the next s_ word; an m_ stall holds the
// following word in S_OUT with its write-back, and s_tready stays low meanwhile.
module fan_level_hysteresis_table import fanlh_pkg::*; #(
    parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // temperature, sensor_index, fan_index
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // rpm_target, fan_level
);

    localparam int AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_WALK = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic [SIDX_W-1:0]        sensor_reg, sensor_next;
    logic [LVL_W-1:0]         level_reg, level_next;
    logic [NUM_SENSORS-1:0]   valid_reg, valid_next;
    logic                     m_valid_reg, m_valid_next;
    logic [RPM_W-1:0]         rpm_reg, rpm_next;
    logic [LVL_W-1:0]         out_lvl_reg, out_lvl_next;

    logic                     s_accept;
    logic                     in_range;
    logic [AW-1:0]            addr;
    logic [AW-1:0]            raddr;
    logic                     ram_we;
    logic [TEMP_W-1:0]        ram_rdata;
    logic signed [TEMP_W-1:0] prev;
    walk_ctrl_t               wctrl;
    walk_stat_t               wstat;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign raddr    = AW'(s_tdata[TEMP_W +: SIDX_W]);
    assign addr     = AW'(sensor_reg);
    assign in_range = ({2'b00, sensor_reg} < 4'(NUM_SENSORS));
    assign prev     = (in_range && valid_reg[addr]) ? $signed(ram_rdata) : '0;

    fanlh_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (NUM_SENSORS)
    ) u_last_temp (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (temp_reg),
        .re    (s_accept),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    fanlh_walk u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (wctrl),
        .stat    (wstat)
    );

    always_comb begin
        state_next   = state_reg;
        temp_next    = temp_reg;
        sensor_next  = sensor_reg;
        level_next   = level_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg;
        rpm_next     = rpm_reg;
        out_lvl_next = out_lvl_reg;
        ram_we       = 1'b0;

        wctrl.start       = 1'b0;
        wctrl.up          = in_range && (temp_reg > prev);
        wctrl.down        = in_range && (temp_reg < prev);
        wctrl.active      = (sensor_reg == ACTIVE_SENSOR);
        wctrl.level       = level_reg;
        wctrl.temperature = temp_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    temp_next   = $signed(s_tdata[TEMP_W-1:0]);
                    sensor_next = s_tdata[TEMP_W +: SIDX_W];
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                wctrl.start = 1'b1;
                state_next  = S_WALK;
            end
            S_WALK: begin
                if (wstat.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    rpm_next     = rpm_at(wstat.level);
                    out_lvl_next = wstat.level;
                    level_next   = wstat.level;
                    if (in_range) begin
                        ram_we           = 1'b1;
                        valid_next[addr] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            level_reg   <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
        temp_reg    <= temp_next;
        sensor_reg  <= sensor_next;
        rpm_reg     <= rpm_next;
        out_lvl_reg <= out_lvl_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RPM_W - LVL_W){1'b0}}, out_lvl_reg, rpm_reg};

endmodule

>>> tb/testbench.sv
module testbench;
    import fanlh_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int CALM_TAIL   = 150;
    localparam int SETTLE      = 30;

    localparam logic [SIDX_W-1:0] SENSOR_FLAT_A = 2'd0;
    localparam logic [SIDX_W-1:0] RATED_SENSOR  = 2'd1;
    localparam logic [SIDX_W-1:0] SENSOR_FLAT_B = 2'd2;
    localparam logic [SIDX_W-1:0] SENSOR_ABSENT = 2'd3;

    localparam int STEP_UP [16] = '{
        25, 38, 41, 44, 47, 52, 47, 52, 60, 63, 66, 69, 75, 75, 75, 75
    };
    localparam int STEP_DOWN [16] = '{
        0, 34, 37, 40, 43, 48, 43, 48, 56, 59, 62, 65, 72, 72, 72, 72
    };
    localparam int STEP_RPM [16] = '{
        0, 2450, 2600, 2800, 3100, 3300, 3100, 3300,
        3700, 4000, 4300, 4600, 5500, 5500, 5500, 5500
    };

    typedef struct {
        logic [S_TDATA_W-1:0] word;
        bit                   drain_first;
    } sample_t;

    typedef struct {
        logic [RPM_W-1:0] rpm;
        logic [LVL_W-1:0] level;
    } fan_reading_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    sample_t      samples_to_send[$];
    fan_reading_t predicted_readings[$];

    int                       fan_level_now = 0;
    logic signed [TEMP_W-1:0] sensor_last [NUM_SENSORS_DEF] = '{default: '0};

    bit           took_sample = 1'b0;
    int           send_gap    = 0;
    int           stall_left  = 0;
    int           quiet_cycles = 0;
    int           errors      = 0;
    fan_reading_t seen;
    wire          calm = samples_to_send.size() < CALM_TAIL;

    fan_level_hysteresis_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int threshold(input bit rising, input int lvl,
                                     input logic [SIDX_W-1:0] sensor);
        if (sensor != RATED_SENSOR)
            return -1;
        return rising ? STEP_UP[lvl] : STEP_DOWN[lvl];
    endfunction

    task automatic advance_fan_level(input logic [S_TDATA_W-1:0] word);
        logic signed [TEMP_W-1:0] t;
        logic [SIDX_W-1:0]        sensor;
        int                       lvl;
        t      = word[7:0];
        sensor = word[9:8];
        lvl    = fan_level_now;
        if (sensor < NUM_SENSORS_DEF) begin
            if (t < sensor_last[sensor]) begin
                while (lvl > 0 && int'(t) <= threshold(1'b0, lvl, sensor))
                    lvl--;
            end else if (t > sensor_last[sensor]) begin
                if (int'(t) >= threshold(1'b1, lvl, sensor)) begin
                    while (lvl + 1 < NUM_LEVELS && int'(t) >= threshold(1'b1, lvl + 1, sensor))
                        lvl++;
                end
            end
            if (lvl >= NUM_LEVELS)
                lvl = NUM_LEVELS - 1;
            sensor_last[sensor] = t;
        end
        fan_level_now = lvl;
        predicted_readings.push_back('{rpm: RPM_W'(STEP_RPM[lvl]), level: LVL_W'(lvl)});
    endtask

    task automatic queue_sample(input int temp, input logic [SIDX_W-1:0] sensor,
                                input bit fan, input bit drain_first);
        sample_t s;
        s.word        = {5'b0, fan, sensor, 8'(temp)};
        s.drain_first = drain_first;
        samples_to_send.push_back(s);
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (took_sample)
                samples_to_send.delete(0);
            if (s_tvalid && !took_sample) begin
                s_tvalid <= 1'b1;
            end else if (!calm && send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (samples_to_send.size() == 0 ||
                         (samples_to_send[0].drain_first && predicted_readings.size() != 0)) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tdata  <= samples_to_send[0].word;
                s_tvalid <= 1'b1;
                if (!calm && $urandom % 8 == 0)
                    send_gap = $urandom_range(1, 11);
            end
        end
    end

    // result sink
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom % 8 == 0)
                stall_left = $urandom_range(1, 11);
        end
    end

    // monitor, checker and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            took_sample <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                advance_fan_level(s_tdata);
            if (m_tvalid && m_tready) begin
                if (predicted_readings.size() == 0) begin
                    $error("unexpected word on m_: %h", m_tdata);
                    errors++;
                end else begin
                    seen = predicted_readings.pop_front();
                    if (m_tdata[12:0] !== seen.rpm) begin
                        $error("rpm_target: expected %0d, actual %0d", seen.rpm, m_tdata[12:0]);
                        errors++;
                    end
                    if (m_tdata[16:13] !== seen.level) begin
                        $error("fan_level: expected %0d, actual %0d", seen.level, m_tdata[16:13]);
                        errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int counted;
        int walk;
        int pick;
        logic [SIDX_W-1:0] sensor;

        queue_sample(30,   RATED_SENSOR,  1'b0, 1'b0);
        queue_sample(38,   RATED_SENSOR,  1'b1, 1'b0);
        queue_sample(127,  RATED_SENSOR,  1'b0, 1'b0);
        queue_sample(100,  RATED_SENSOR,  1'b0, 1'b0);
        queue_sample(73,   RATED_SENSOR,  1'b1, 1'b0);
        queue_sample(72,   RATED_SENSOR,  1'b0, 1'b0);
        queue_sample(-128, RATED_SENSOR,  1'b0, 1'b0);
        queue_sample(0,    RATED_SENSOR,  1'b1, 1'b0);
        queue_sample(41,   RATED_SENSOR,  1'b0, 1'b0);
        queue_sample(52,   RATED_SENSOR,  1'b0, 1'b0);
        queue_sample(48,   RATED_SENSOR,  1'b0, 1'b0);
        queue_sample(43,   RATED_SENSOR,  1'b1, 1'b0);
        queue_sample(43,   RATED_SENSOR,  1'b0, 1'b0);
        queue_sample(-1,   SENSOR_FLAT_A, 1'b0, 1'b0);
        queue_sample(5,    SENSOR_FLAT_A, 1'b1, 1'b0);
        queue_sample(-1,   SENSOR_FLAT_A, 1'b0, 1'b0);
        queue_sample(127,  SENSOR_FLAT_B, 1'b0, 1'b0);
        queue_sample(50,   SENSOR_ABSENT, 1'b1, 1'b0);
        queue_sample(-128, SENSOR_FLAT_B, 1'b0, 1'b0);
        queue_sample(-128, SENSOR_FLAT_B, 1'b1, 1'b0);
        queue_sample(-128, SENSOR_ABSENT, 1'b0, 1'b0);
        queue_sample(60,   RATED_SENSOR,  1'b1, 1'b1);

        counted = 0;
        walk    = 60;
        while (counted < 1900) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                walk = walk + $urandom_range(0, 16) - 8;
                if (walk < 15) walk = 15;
                if (walk > 85) walk = 85;
                queue_sample(walk, RATED_SENSOR, $urandom_range(0, 1), counted == 950);
                counted++;
            end else if (pick < 75) begin
                sensor = ($urandom % 2 == 0) ? SENSOR_FLAT_A : SENSOR_FLAT_B;
                queue_sample($urandom_range(0, 8) - 4, sensor, $urandom_range(0, 1), 1'b0);
                counted++;
            end else if (pick < 92) begin
                queue_sample($urandom_range(0, 255), $urandom_range(0, 2),
                             $urandom_range(0, 1), 1'b0);
                counted++;
            end else begin
                queue_sample($urandom_range(0, 255), SENSOR_ABSENT, $urandom_range(0, 1), 1'b0);
                counted++;
            end
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (samples_to_send.size() == 0 && !s_tvalid);
        wait (predicted_readings.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
